/* hdl/dss_pkg.sv */
// ---------------------------------------------------------------------------
// dss_pkg: shared types and constants for the disk scan scheduler
// Payload structs, register indexes, reset values and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_QUEUE_DEF = 16;
    localparam int CYL_W         = 12;
    localparam int SUM_W         = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_CYLINDER = 2'd2;

    // Configuration reset values
    localparam logic [CYL_W-1:0] HEAD_START_RST    = 12'd0;
    localparam logic             SWEEP_RIGHT_RST   = 1'b1;
    localparam logic [CYL_W-1:0] LAST_CYLINDER_RST = 12'd199;

    typedef struct packed {
        logic [CYL_W-1:0] cylinder;
        logic             batch_end;
    } in_item_t;

    typedef struct packed {
        logic [CYL_W-1:0] stop_cylinder;
        logic [SUM_W-1:0] seek_total;
        logic             overflow;
        logic             final_stop;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic ins;            // insert the accepted request
        logic start;          // load head, clear seek sum, rewind pointer
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_load_split;
        logic save_split;
        logic emit;           // load the output register with a stop
        logic emit_edge;      // stop is the disk edge, not a stored request
        logic rd_desc;        // read entry ptr-1 instead of ptr
        logic final_stop;
        logic clear_batch;    // empty the queue and drop flag
    } dss_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_lt;        // entry at ptr is valid and below the head
        logic ptr_at_count;
        logic ptr_zero;
        logic ptr_last_asc;   // ptr addresses the last stored entry
        logic ptr_one;
        logic split_zero;
        logic split_full;
        logic out_free;       // output register can take a stop this cycle
    } dss_status_t;

endpackage

/* hdl/dss_datapath.sv */
// ---------------------------------------------------------------------------
// dss_datapath: sorted request chain, head tracking and output register
// Holds the requests in an ascending insertion chain, the scan pointer,
// the split point, head position, seek sum and the result register.
// ---------------------------------------------------------------------------
module dss_datapath #(
    parameter int MAX_QUEUE = dss_pkg::MAX_QUEUE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dss_pkg::dss_cmd_t             cmd,
    output dss_pkg::dss_status_t          status,
    input  logic [dss_pkg::CYL_W-1:0]     req_cylinder,
    input  logic [dss_pkg::CYL_W-1:0]     head_start,
    input  logic                          sweep_right,
    input  logic [dss_pkg::CYL_W-1:0]     last_cylinder,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dss_pkg::out_item_t            m_data
);
    import dss_pkg::*;

    localparam int CNT_W = $clog2(MAX_QUEUE + 1);
    localparam int IDX_W = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;

    logic [CYL_W-1:0] cell_reg  [MAX_QUEUE];
    logic [CYL_W-1:0] cell_next [MAX_QUEUE];
    logic [MAX_QUEUE-1:0] gt;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] split_reg, split_next;
    logic             dropped_reg, dropped_next;
    logic [CYL_W-1:0] head_reg, head_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic [CYL_W-1:0] ins_cyl;
    logic [CYL_W-1:0] start_head;
    logic [CNT_W-1:0] rd_ptr;
    logic [IDX_W-1:0] rd_idx;
    logic [CYL_W-1:0] rd_data;
    logic [CYL_W-1:0] stop_cyl;
    logic [CYL_W-1:0] step_dist;
    logic [SUM_W-1:0] stop_sum;
    logic             full;

    // Saturate requests and head start to the far edge
    assign ins_cyl    = (req_cylinder > last_cylinder) ? last_cylinder : req_cylinder;
    assign start_head = (head_start > last_cylinder) ? last_cylinder : head_start;
    assign full       = (count_reg == CNT_W'(MAX_QUEUE));

    // Insertion chain: each cell shifts up when its lower neighbor is larger
    always_comb begin
        for (int i = 0; i < MAX_QUEUE; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] > ins_cyl);
        end
        for (int i = 0; i < MAX_QUEUE; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.ins && !full && (CNT_W'(i) <= count_reg)) begin
                if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end else if ((CNT_W'(i) == count_reg) || gt[i]) begin
                    cell_next[i] = ins_cyl;
                end
            end
        end
    end

    // Single read port into the chain
    assign rd_ptr = cmd.rd_desc ? (ptr_reg - CNT_W'(1)) : ptr_reg;
    assign rd_idx = rd_ptr[IDX_W-1:0];
    assign rd_data = (32'(rd_idx) < MAX_QUEUE) ? cell_reg[rd_idx] : '0;

    assign stop_cyl  = cmd.emit_edge ? (sweep_right ? last_cylinder : '0) : rd_data;
    assign step_dist = (stop_cyl >= head_reg) ? (stop_cyl - head_reg) : (head_reg - stop_cyl);
    assign stop_sum  = sum_reg + SUM_W'(step_dist);

    always_comb begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        ptr_next       = ptr_reg;
        split_next     = split_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.ins) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.start) begin
            head_next = start_head;
            sum_next  = '0;
            ptr_next  = '0;
        end
        if (cmd.save_split) begin
            split_next = ptr_reg;
        end
        if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + CNT_W'(1);
        end else if (cmd.ptr_dec) begin
            ptr_next = ptr_reg - CNT_W'(1);
        end else if (cmd.ptr_load_split) begin
            ptr_next = split_reg;
        end

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            head_next                   = stop_cyl;
            sum_next                    = stop_sum;
            out_valid_next              = 1'b1;
            out_data_next.stop_cylinder = stop_cyl;
            out_data_next.seek_total    = stop_sum;
            out_data_next.overflow      = dropped_reg;
            out_data_next.final_stop    = cmd.final_stop;
        end
        if (cmd.clear_batch) begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            ptr_reg       <= '0;
            split_reg     <= '0;
            head_reg      <= HEAD_START_RST;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            ptr_reg       <= ptr_next;
            split_reg     <= split_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

    assign status.scan_lt      = (ptr_reg < count_reg) && (rd_data < head_reg);
    assign status.ptr_at_count = (ptr_reg == count_reg);
    assign status.ptr_zero     = (ptr_reg == '0);
    assign status.ptr_last_asc = ((ptr_reg + CNT_W'(1)) == count_reg);
    assign status.ptr_one      = (ptr_reg == CNT_W'(1));
    assign status.split_zero   = (split_reg == '0);
    assign status.split_full   = (split_reg == count_reg);
    assign status.out_free     = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* hdl/dss_ctrl.sv */
// ---------------------------------------------------------------------------
// dss_ctrl: schedule sequencer
// Collects requests, finds the split point, then walks the first sweep,
// the edge stop and the return sweep, one stop per free output slot.
// ---------------------------------------------------------------------------
module dss_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  batch_end,
    input  logic                  sweep_right,
    input  dss_pkg::dss_status_t  status,
    output dss_pkg::dss_cmd_t     cmd
);
    import dss_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FIRST  = 3'd2;
    localparam logic [2:0] ST_EDGE   = 3'd3;
    localparam logic [2:0] ST_SECOND = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       fin;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        fin        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.ins = 1'b1;
                    if (batch_end) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // advance past requests below the head
                if (status.scan_lt) begin
                    cmd.ptr_inc = 1'b1;
                end else begin
                    cmd.save_split = 1'b1;
                    state_next     = ST_FIRST;
                end
            end
            ST_FIRST: begin
                cmd.rd_desc = !sweep_right;
                if (sweep_right ? status.ptr_at_count : status.ptr_zero) begin
                    state_next = ST_EDGE;
                end else if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.ptr_inc = sweep_right;
                    cmd.ptr_dec = !sweep_right;
                end
            end
            ST_EDGE: begin
                fin = sweep_right ? status.split_zero : status.split_full;
                if (status.out_free) begin
                    cmd.emit           = 1'b1;
                    cmd.emit_edge      = 1'b1;
                    cmd.final_stop     = fin;
                    cmd.ptr_load_split = 1'b1;
                    cmd.clear_batch    = fin;
                    state_next         = fin ? ST_IDLE : ST_SECOND;
                end
            end
            ST_SECOND: begin
                cmd.rd_desc = sweep_right;
                fin = sweep_right ? status.ptr_one : status.ptr_last_asc;
                if (status.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.ptr_inc     = !sweep_right;
                    cmd.ptr_dec     = sweep_right;
                    cmd.final_stop  = fin;
                    cmd.clear_batch = fin;
                    if (fin) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/disk_scan_scheduler.sv */
// ---------------------------------------------------------------------------
// disk_scan_scheduler: SCAN (elevator) disk schedule
// Loads a batch of cylinder requests into a sorted chain and, on the
// request that closes the batch, emits every stop of the elevator sweep
// with the running seek total.
// ---------------------------------------------------------------------------
//  channel  | ports                       | payload
//  ---------+-----------------------------+----------------------------------
//  input    | s_valid  s_ready  s_data    | cylinder, batch_end
//  result   | m_valid  m_ready  m_data    | stop_cylinder, seek_total,
//           |                             | overflow, final_stop
//  config   | cfg_valid cfg_ready         | cfg_index, cfg_data
//
//  A request is taken only while the sequencer is idle and is inserted into
//  the sorted chain the cycle it is accepted. After the batch-end transaction
//  the split scan walks the chain one entry per cycle, then one stop leaves
//  per cycle while the result channel is free, with a step that emits no
//  stop between the first sweep and the edge stop. A stalled result channel
//  holds the sequencer; input is refused until the last stop is loaded.
//  Reset clears the queue and flags and loads the configuration defaults.
// ---------------------------------------------------------------------------
module disk_scan_scheduler #(
    parameter int MAX_QUEUE = dss_pkg::MAX_QUEUE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dss_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dss_pkg::out_item_t                 m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dss_pkg::*;

    logic [CYL_W-1:0] head_start_reg, head_start_next;
    logic             sweep_right_reg, sweep_right_next;
    logic [CYL_W-1:0] last_cyl_reg, last_cyl_next;

    dss_cmd_t    cmd;
    dss_status_t status;

    // Configuration is always taken; unknown indexes drop the write
    assign cfg_ready = 1'b1;

    always_comb begin
        head_start_next  = head_start_reg;
        sweep_right_next = sweep_right_reg;
        last_cyl_next    = last_cyl_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HEAD_START:    head_start_next  = cfg_data[CYL_W-1:0];
                CFG_SWEEP_RIGHT:   sweep_right_next = cfg_data[0];
                CFG_LAST_CYLINDER: last_cyl_next    = cfg_data[CYL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_start_reg  <= HEAD_START_RST;
            sweep_right_reg <= SWEEP_RIGHT_RST;
            last_cyl_reg    <= LAST_CYLINDER_RST;
        end else begin
            head_start_reg  <= head_start_next;
            sweep_right_reg <= sweep_right_next;
            last_cyl_reg    <= last_cyl_next;
        end
    end

    // Sequencer: decides each cycle's insert, scan step or stop
    dss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .batch_end   (s_data.batch_end),
        .sweep_right (sweep_right_reg),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: sorted chain, head, seek sum and result register
    dss_datapath #(
        .MAX_QUEUE (MAX_QUEUE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .req_cylinder  (s_data.cylinder),
        .head_start    (head_start_reg),
        .sweep_right   (sweep_right_reg),
        .last_cylinder (last_cyl_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule
